// File: hw/rtl/tncf_pkg.sv
package tncf_pkg;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       chunk_last;
  } tncf_in_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    logic       chunk_end;
    logic       binary_mode;
  } tncf_out_t;

  // parse state, one-hot
  typedef enum logic [3:0] {
    MODE_DATA   = 4'b0001,
    MODE_IAC    = 4'b0010,
    MODE_OPTION = 4'b0100,
    MODE_SUB    = 4'b1000
  } tncf_mode_t;

  // pending negotiation verb
  typedef enum logic [1:0] {
    VERB_WILL = 2'd0,
    VERB_WONT = 2'd1,
    VERB_DO   = 2'd2,
    VERB_DONT = 2'd3
  } tncf_verb_t;

  localparam logic [7:0] TN_SE   = 8'hF0;
  localparam logic [7:0] TN_NOP  = 8'hF1;
  localparam logic [7:0] TN_DM   = 8'hF2;
  localparam logic [7:0] TN_BRK  = 8'hF3;
  localparam logic [7:0] TN_IP   = 8'hF4;
  localparam logic [7:0] TN_AO   = 8'hF5;
  localparam logic [7:0] TN_AYT  = 8'hF6;
  localparam logic [7:0] TN_EC   = 8'hF7;
  localparam logic [7:0] TN_EL   = 8'hF8;
  localparam logic [7:0] TN_GA   = 8'hF9;
  localparam logic [7:0] TN_SB   = 8'hFA;
  localparam logic [7:0] TN_WILL = 8'hFB;
  localparam logic [7:0] TN_WONT = 8'hFC;
  localparam logic [7:0] TN_DO   = 8'hFD;
  localparam logic [7:0] TN_DONT = 8'hFE;
  localparam logic [7:0] TN_IAC  = 8'hFF;

  localparam logic [7:0] OPT_BINARY = 8'h00;
  localparam logic [7:0] BACKSPACE  = 8'h08;

  localparam int unsigned BUF_DEPTH = 2;

endpackage

// File: hw/rtl/telnet_receive_command_filter_top.sv
// channel | ports                        | payload
// input   | in_valid, in_ready, in_data  | tncf_in_t  (rx_byte, chunk_last)
// result  | out_valid, out_ready, out_data | tncf_out_t (data_byte, data_valid,
//         |                              |   chunk_end, binary_mode)
// one byte per cycle while in_ready is high; every input transfer gives exactly one result transfer
// result is formed combinationally by the parser and registered in a two-entry buffer
// input stalls only while two results wait for out_ready
// rst_n synchronous, active low: normal data mode, binary off, buffer empty
module telnet_receive_command_filter_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tncf_pkg::tncf_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tncf_pkg::tncf_out_t out_data
);

  logic                accept;
  tncf_pkg::tncf_out_t result;

  assign accept = in_valid && in_ready;

  tncf_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_data),
    .result (result)
  );

  tncf_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (result),
    .not_full  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: hw/rtl/tncf_parser.sv
module tncf_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  tncf_pkg::tncf_in_t  item,
  output tncf_pkg::tncf_out_t result
);

  tncf_pkg::tncf_mode_t mode_r, mode_nxt;
  tncf_pkg::tncf_verb_t verb_r, verb_nxt;
  logic                 bin_r, bin_nxt;
  logic [7:0]           data;
  logic                 valid;
  logic [7:0]           b;

  assign b = item.rx_byte;

  always_comb begin
    mode_nxt = mode_r;
    verb_nxt = verb_r;
    bin_nxt  = bin_r;
    data     = 8'h00;
    valid    = 1'b0;
    unique case (mode_r)
      tncf_pkg::MODE_DATA: begin
        if (b == tncf_pkg::TN_IAC) begin
          mode_nxt = tncf_pkg::MODE_IAC;
        end else begin
          data  = b;
          valid = 1'b1;
        end
      end
      tncf_pkg::MODE_IAC: begin
        mode_nxt = tncf_pkg::MODE_DATA;
        unique case (b) inside
          tncf_pkg::TN_IAC: begin
            data  = tncf_pkg::TN_IAC;
            valid = 1'b1;
          end
          tncf_pkg::TN_EC: begin
            data  = tncf_pkg::BACKSPACE;
            valid = 1'b1;
          end
          tncf_pkg::TN_WILL, tncf_pkg::TN_WONT, tncf_pkg::TN_DO, tncf_pkg::TN_DONT: begin
            verb_nxt = tncf_pkg::tncf_verb_t'(b[1:0] + 2'd1);
            mode_nxt = tncf_pkg::MODE_OPTION;
          end
          tncf_pkg::TN_SE, tncf_pkg::TN_NOP, tncf_pkg::TN_DM, tncf_pkg::TN_BRK,
          tncf_pkg::TN_IP, tncf_pkg::TN_AO, tncf_pkg::TN_AYT, tncf_pkg::TN_GA,
          tncf_pkg::TN_EL: begin
            valid = 1'b0;
          end
          tncf_pkg::TN_SB: begin
            mode_nxt = tncf_pkg::MODE_SUB;
          end
          default: begin
            data  = b;
            valid = 1'b1;
          end
        endcase
      end
      tncf_pkg::MODE_OPTION: begin
        mode_nxt = tncf_pkg::MODE_DATA;
        if (b == tncf_pkg::OPT_BINARY) begin
          if (verb_r == tncf_pkg::VERB_WILL) begin
            bin_nxt = 1'b1;
          end else if (verb_r == tncf_pkg::VERB_WONT) begin
            bin_nxt = 1'b0;
          end
        end
      end
      tncf_pkg::MODE_SUB: begin
        if (b == tncf_pkg::TN_SE) begin
          mode_nxt = tncf_pkg::MODE_DATA;
        end
      end
      default: begin
        mode_nxt = tncf_pkg::MODE_DATA;
      end
    endcase
  end

  assign result.data_byte   = data;
  assign result.data_valid  = valid;
  assign result.chunk_end   = item.chunk_last;
  assign result.binary_mode = bin_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= tncf_pkg::MODE_DATA;
      verb_r <= tncf_pkg::VERB_WILL;
      bin_r  <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      verb_r <= verb_nxt;
      bin_r  <= bin_nxt;
    end
  end

  a_sub_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == tncf_pkg::MODE_SUB |-> !result.data_valid)
    else $error("data produced inside subnegotiation");

  a_opt_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == tncf_pkg::MODE_OPTION |-> !result.data_valid)
    else $error("option byte produced data");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !result.data_valid |-> result.data_byte == 8'h00)
    else $error("data byte not zero without data");

  a_flag_only_option: assert property (@(posedge clk) disable iff (!rst_n)
    accept && mode_r != tncf_pkg::MODE_OPTION |=> $stable(bin_r))
    else $error("binary flag changed outside option byte");

endmodule

// File: hw/rtl/tncf_out_buf.sv
module tncf_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tncf_pkg::tncf_out_t push_data,
  output logic                not_full,
  output logic                out_valid,
  input  logic                out_ready,
  output tncf_pkg::tncf_out_t out_data
);

  tncf_pkg::tncf_out_t mem_r [tncf_pkg::BUF_DEPTH];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       pop;

  assign not_full  = count_r != 2'(tncf_pkg::BUF_DEPTH);
  assign out_valid = count_r != 2'd0;
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'(tncf_pkg::BUF_DEPTH))
    else $error("result buffer count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> not_full)
    else $error("transfer into full result buffer");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 2'd1)
    else $error("result buffer count did not advance");

endmodule
